// ===== src/bffa_pkg.sv =====
`default_nettype none
package bffa_pkg;

	// field widths of the request, result and register interfaces
	localparam int IDX_W    = 12;
	localparam int STAT_W   = 2;
	localparam int FREE_W   = 13;
	localparam int POOL_W   = 13;
	localparam int REQ_DW   = 16;
	localparam int RES_DW   = 32;
	localparam int RES_PAD  = RES_DW - IDX_W - STAT_W - FREE_W;
	localparam int CFG_DW   = 13;

	// default geometry
	localparam int DEF_ENTRIES   = 4096;
	localparam int DEF_WORD_BITS = 64;

	// register reset values
	localparam logic [POOL_W-1:0] POOL_RESET = 13'd4096;

	// register indexes
	localparam logic REG_POOL_SIZE   = 1'b0;
	localparam logic REG_FIRST_INDEX = 1'b1;

	// request kinds
	localparam logic REQ_ALLOC   = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_RANGE = 2'd2,
		STAT_FREE  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ALLOC,
		S_FREE_RD,
		S_FREE_CHK,
		S_RESP
	} state_t;

endpackage
`default_nettype wire

// ===== src/bffa_ram.sv =====
`default_nettype none
module bffa_ram #(
	parameter int WIDTH  = 64,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== src/bitmap_first_fit_allocator.sv =====
// allocate: one bitmap word read per cycle, from the lowest word up to the first word with a
//   free bit in the pool or the pool's last word; S_RESP then registers the result
// free: word read in S_FREE_RD, checked and cleared in S_FREE_CHK, then S_RESP
// empty-pool allocate or out-of-range free: S_RESP directly; one request in flight, the next
//   taken back in S_IDLE, entered as the result is registered; reset: asynchronous, active low
// a clearing pass then writes NWORDS words, one per cycle, with no requests taken meanwhile
`default_nettype none
module bitmap_first_fit_allocator
	import bffa_pkg::*;
#(
	parameter int ENTRIES   = DEF_ENTRIES,
	parameter int WORD_BITS = DEF_WORD_BITS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// request stream
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [REQ_DW-1:0] s_axis_tdata,  // release_index[11:0], zero pad
	input  wire logic [0:0]        s_axis_tuser,  // req_type[0]
	// result stream
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic      [RES_DW-1:0] m_axis_tdata,  // granted_index[11:0], status[13:12],
	                                              // free_count[26:14], zero pad
	// register writes
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic              cfg_index,
	input  wire logic [CFG_DW-1:0] cfg_data
);

	localparam int NWORDS = (ENTRIES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int PBW    = $clog2(WORD_BITS);
	localparam int BW     = $clog2(ENTRIES + WORD_BITS + 1);
	localparam int CW     = (BW > POOL_W) ? BW : POOL_W;
	localparam int UCW    = $clog2(ENTRIES + 1);

	state_t state_q, state_d;

	logic [POOL_W-1:0]    pool_size_q;
	logic                 first_index_q;
	logic [UCW-1:0]       used_count_q;

	logic [IDX_W-1:0]     idx_q;
	logic [AW-1:0]        word_q;
	logic [CW-1:0]        base_q;
	logic                 rd_vld_q;
	logic [AW-1:0]        chk_word_q;
	logic [CW-1:0]        chk_base_q;
	logic                 chk_last_q;
	logic [IDX_W-1:0]     res_granted_q;
	status_t              res_status_q;

	logic                 m_valid_q;
	logic [IDX_W-1:0]     m_granted_q;
	status_t              m_status_q;
	logic [FREE_W-1:0]    m_free_q;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic                 ram_re;
	logic [AW-1:0]        ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	logic                 s_fire;
	logic                 req_in;
	logic [CW-1:0]        idx_in_ext;
	logic [CW-1:0]        pool_ext;
	logic [CW-1:0]        sz_c;
	logic [CW-1:0]        fi_ext;
	logic [CW-1:0]        lim_c;
	logic [WORD_BITS-1:0] avail_c;
	logic [PBW-1:0]       pos_c;
	logic                 hit_c;
	logic                 alloc_hit;
	logic                 alloc_done;
	logic                 alloc_issue;
	logic [PBW-1:0]       bit_c;
	logic                 rel_set_c;
	logic [CW-1:0]        span_c;
	logic [CW-1:0]        used_ext;
	logic [CW-1:0]        free_c;
	logic                 resp_go;

	// effective pool size and request decode
	assign pool_ext   = CW'(pool_size_q);
	assign sz_c       = (pool_ext > CW'(ENTRIES)) ? CW'(ENTRIES) : pool_ext;
	assign fi_ext     = CW'(first_index_q);
	assign s_fire     = s_axis_tvalid && s_axis_tready;
	assign req_in     = s_axis_tuser[0];
	assign idx_in_ext = CW'(s_axis_tdata[IDX_W-1:0]);

	// free bits of the word under check, within the pool
	assign lim_c = sz_c - chk_base_q;
	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			avail_c[b] = !ram_rdata[b] && (CW'(b) < lim_c);
		end
		if (first_index_q && (chk_base_q == '0)) begin
			avail_c[0] = 1'b0;
		end
	end

	// lowest free bit
	always_comb begin
		pos_c = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (avail_c[b]) begin
				pos_c = PBW'(b);
			end
		end
	end
	assign hit_c = |avail_c;

	assign alloc_hit   = (state_q == S_ALLOC) && rd_vld_q && hit_c;
	assign alloc_done  = (state_q == S_ALLOC) && rd_vld_q && (hit_c || chk_last_q);
	assign alloc_issue = (state_q == S_ALLOC) && !(rd_vld_q && (hit_c || chk_last_q));

	// release lookup, word and bit split straight from the index (power of two word)
	assign bit_c     = idx_q[PBW-1:0];
	assign rel_set_c = ram_rdata[bit_c];

	// free count from the used count
	assign span_c   = (sz_c > fi_ext) ? (sz_c - fi_ext) : '0;
	assign used_ext = CW'(used_count_q);
	assign free_c   = (span_c > used_ext) ? (span_c - used_ext) : '0;

	assign resp_go = (state_q == S_RESP) && (!m_valid_q || m_axis_tready);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (word_q == AW'(NWORDS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_fire) begin
					if (req_in == REQ_ALLOC) begin
						state_d = (sz_c > fi_ext) ? S_ALLOC : S_RESP;
					end else begin
						state_d = (idx_in_ext >= sz_c) ? S_RESP : S_FREE_RD;
					end
				end
			end
			S_ALLOC: begin
				if (alloc_done) begin
					state_d = S_RESP;
				end
			end
			S_FREE_RD: begin
				state_d = S_FREE_CHK;
			end
			S_FREE_CHK: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				if (resp_go) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// ram controls
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = word_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = word_q;
		unique case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
			end
			S_ALLOC: begin
				if (alloc_hit) begin
					ram_we    = 1'b1;
					ram_waddr = chk_word_q;
					ram_wdata = ram_rdata | (WORD_BITS'(1) << pos_c);
				end else if (alloc_issue) begin
					ram_re = 1'b1;
				end
			end
			S_FREE_RD: begin
				ram_re = 1'b1;
			end
			S_FREE_CHK: begin
				if (rel_set_c) begin
					ram_we    = 1'b1;
					ram_wdata = ram_rdata & ~(WORD_BITS'(1) << bit_c);
				end
			end
			S_IDLE, S_RESP: begin
				ram_we = 1'b0;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready     = 1'b1;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			word_q        <= '0;
			base_q        <= '0;
			rd_vld_q      <= 1'b0;
			used_count_q  <= '0;
			pool_size_q   <= POOL_RESET;
			first_index_q <= 1'b0;
			m_valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;

			// register writes
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_POOL_SIZE:   pool_size_q   <= cfg_data[POOL_W-1:0];
					REG_FIRST_INDEX: first_index_q <= cfg_data[0];
					default:         pool_size_q   <= pool_size_q;
				endcase
			end

			// word walker
			if (state_q == S_CLEAR) begin
				word_q <= word_q + AW'(1);
			end else if (s_fire) begin
				word_q   <= (req_in == REQ_RELEASE) ? AW'(idx_in_ext >> PBW) : '0;
				base_q   <= '0;
				rd_vld_q <= 1'b0;
			end else if (alloc_issue) begin
				word_q   <= word_q + AW'(1);
				base_q   <= base_q + CW'(WORD_BITS);
				rd_vld_q <= 1'b1;
			end

			// used count
			if (alloc_hit) begin
				used_count_q <= used_count_q + UCW'(1);
			end else if ((state_q == S_FREE_CHK) && rel_set_c && (used_count_q != '0)) begin
				used_count_q <= used_count_q - UCW'(1);
			end

			// result register
			if (resp_go) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (s_fire) begin
			idx_q         <= s_axis_tdata[IDX_W-1:0];
			res_granted_q <= '0;
			res_status_q  <= (req_in == REQ_ALLOC) ? STAT_FULL : STAT_RANGE;
		end
		if (alloc_issue) begin
			chk_word_q <= word_q;
			chk_base_q <= base_q;
			chk_last_q <= (base_q + CW'(WORD_BITS)) >= sz_c;
		end
		if (alloc_hit) begin
			res_granted_q <= IDX_W'(chk_base_q + CW'(pos_c));
			res_status_q  <= STAT_OK;
		end
		if (state_q == S_FREE_CHK) begin
			res_status_q <= rel_set_c ? STAT_OK : STAT_FREE;
		end
		if (resp_go) begin
			m_granted_q <= res_granted_q;
			m_status_q  <= res_status_q;
			m_free_q    <= FREE_W'(free_c);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{RES_PAD{1'b0}}, m_free_q, m_status_q, m_granted_q};

	bffa_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (NWORDS),
		.ADDR_W(AW)
	) u_bitmap (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

`ifndef SYNTH
	// used count never exceeds the entry count
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_count_q <= UCW'(ENTRIES))
		else $error("used count above entry count");

	// a granted entry lies inside the pool
	a_grant_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		alloc_hit |-> ((chk_base_q + CW'(pos_c)) < sz_c) &&
			((chk_base_q + CW'(pos_c)) >= fi_ext))
		else $error("granted entry outside the pool");

	// releasing a set bit implies entries are counted as used
	a_release_counted: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_FREE_CHK) && rel_set_c) |-> (used_count_q != '0))
		else $error("release of a set bit with zero used count");

	// a finished request shows up on the result port next cycle
	a_resp_out: assert property (@(posedge clk) disable iff (!arst_n)
		resp_go |=> m_axis_tvalid && (state_q == S_IDLE))
		else $error("result not presented after completion");

	// the ram is never read and written in the same cycle
	a_ram_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("bitmap ram read and write collide");
`endif

endmodule
`default_nettype wire

// ===== sim/grant_checker.sv =====
module grant_checker
	import bffa_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	input  wire logic              s_axis_tready,
	input  wire logic [REQ_DW-1:0] s_axis_tdata,  // release_index[11:0], zero pad
	input  wire logic [0:0]        s_axis_tuser,  // req_type[0]
	input  wire logic              m_axis_tvalid,
	input  wire logic              m_axis_tready,
	input  wire logic [RES_DW-1:0] m_axis_tdata,  // granted_index[11:0], status[13:12],
	                                              // free_count[26:14], zero pad
	input  wire logic              cfg_valid,
	input  wire logic              cfg_ready,
	input  wire logic              cfg_index,
	input  wire logic [CFG_DW-1:0] cfg_data,
	output int                     mismatches,
	output int                     outstanding
);

	typedef struct {
		logic [IDX_W-1:0]  index;
		status_t           status;
		logic [FREE_W-1:0] free;
	} grant_t;

	// shadow copy of the bitmap, used count and registers
	logic [DEF_ENTRIES-1:0] used_map;
	int                     used_cnt;
	logic [POOL_W-1:0]      pool_sz;
	logic                   first_idx;
	grant_t                 expected_grants[$];

	// apply one request to the shadow state and return the result it yields
	function automatic grant_t compute_grant(input logic kind, input logic [IDX_W-1:0] idx);
		grant_t r;
		int     lim;
		int     span;
		bit     found;
		lim = (pool_sz > DEF_ENTRIES) ? DEF_ENTRIES : int'(pool_sz);
		r.index = '0;
		found = 1'b0;
		if (kind == REQ_ALLOC) begin
			// first fit from the lowest allocatable index
			r.status = STAT_FULL;
			for (int i = int'(first_idx); i < lim && !found; i++) begin
				if (!used_map[i]) begin
					used_map[i] = 1'b1;
					used_cnt++;
					r.index = IDX_W'(i);
					r.status = STAT_OK;
					found = 1'b1;
				end
			end
		end else if (int'(idx) >= lim) begin
			r.status = STAT_RANGE;
		end else if (!used_map[idx]) begin
			r.status = STAT_FREE;
		end else begin
			// entries below first_index may still be returned
			used_map[idx] = 1'b0;
			if (used_cnt > 0)
				used_cnt--;
			r.status = STAT_OK;
		end
		// free entries saturate at zero when a shrunk pool still holds entries
		span = (lim > int'(first_idx)) ? lim - int'(first_idx) : 0;
		r.free = FREE_W'((span > used_cnt) ? span - used_cnt : 0);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		grant_t           exp_g;
		logic [IDX_W-1:0]  got_index;
		status_t           got_status;
		logic [FREE_W-1:0] got_free;
		if (!arst_n) begin
			used_map = '0;
			used_cnt = 0;
			pool_sz = POOL_RESET;
			first_idx = 1'b0;
			expected_grants.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_POOL_SIZE)
					pool_sz = cfg_data[POOL_W-1:0];
				else
					first_idx = cfg_data[0];
			end

			// results against the oldest expectation
			if (m_axis_tvalid && m_axis_tready) begin
				got_index  = m_axis_tdata[IDX_W-1:0];
				got_status = status_t'(m_axis_tdata[IDX_W+STAT_W-1:IDX_W]);
				got_free   = m_axis_tdata[IDX_W+STAT_W+FREE_W-1:IDX_W+STAT_W];
				if (expected_grants.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result: index %0d status %0d free %0d",
							got_index, got_status, got_free);
					mismatches++;
				end else begin
					exp_g = expected_grants.pop_front();
					if (got_index !== exp_g.index || got_status !== exp_g.status ||
							got_free !== exp_g.free) begin
						if (mismatches < 10)
							$display("result mismatch: expected index %0d status %0d free %0d",
								exp_g.index, exp_g.status, exp_g.free,
								", got index %0d status %0d free %0d",
								got_index, got_status, got_free);
						mismatches++;
					end
				end
			end

			// accepted request
			if (s_axis_tvalid && s_axis_tready)
				expected_grants.push_back(compute_grant(s_axis_tuser[0],
					s_axis_tdata[IDX_W-1:0]));

			outstanding = expected_grants.size();
		end
	end

endmodule

// ===== sim/bitmap_first_fit_allocator_tb.sv =====
module bitmap_first_fit_allocator_tb;
	import bffa_pkg::*;

	localparam int SETTLE_CYCLES = 80;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 200;
	localparam int TIMEOUT       = 4_000_000;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [REQ_DW-1:0] s_axis_tdata;
	logic [0:0]        s_axis_tuser;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [RES_DW-1:0] m_axis_tdata;
	logic              cfg_valid;
	logic              cfg_ready;
	logic              cfg_index;
	logic [CFG_DW-1:0] cfg_data;
	int                mismatches;
	int                outstanding;

	// stimulus shaping state
	bit idle_on;
	int cur_pool;
	int guess_used;

	int phase_pool[PHASES] = '{64, 4096, 130, 1, 8191, 8, 0, 0};
	int phase_fill[PHASES] = '{75, 70, 60, 50, 65, 55, 50, 60};

	bitmap_first_fit_allocator uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	grant_checker grant_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		#(TIMEOUT);
		$display("bitmap_first_fit_allocator test failed");
		$finish;
	end

	// one register write, then valid is dropped before the task returns
	task automatic write_reg(input logic idx, input logic [CFG_DW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// stop offering, wait for every result, then let the block settle
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// registers change only while the block is idle
	task automatic configure(input logic [POOL_W-1:0] pool, input logic first);
		wait_drained();
		write_reg(REG_POOL_SIZE, pool);
		write_reg(REG_FIRST_INDEX, {{(CFG_DW-1){1'b0}}, first});
		cur_pool = int'(pool);
	endtask

	// offer one request after a random gap; valid stays high when the gap is zero
	task automatic send_request(input logic kind, input logic [IDX_W-1:0] idx);
		int gap;
		gap = idle_on ? $urandom_range(11, 0) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {{(REQ_DW-IDX_W){1'b0}}, idx};
		do @(posedge clk); while (!s_axis_tready);
		if (kind == REQ_ALLOC)
			guess_used++;
		else if (guess_used > 0)
			guess_used--;
	endtask

	// random request, frees aimed mostly at the low, likely used region
	task automatic send_random(input int alloc_pct);
		int               lim;
		int               pick;
		logic             kind;
		logic [IDX_W-1:0] idx;
		lim = (cur_pool > DEF_ENTRIES) ? DEF_ENTRIES : cur_pool;
		if (guess_used > lim)
			guess_used = lim;
		kind = ($urandom_range(99, 0) < alloc_pct) ? REQ_ALLOC : REQ_RELEASE;
		pick = $urandom_range(99, 0);
		idx = IDX_W'($urandom);
		if (kind == REQ_RELEASE) begin
			if (pick < 65)
				idx = IDX_W'($urandom_range(guess_used + 2, 0));
			else if (pick < 75)
				idx = IDX_W'(lim - 1);
			else if (pick < 85)
				idx = IDX_W'(lim);
		end
		send_request(kind, idx);
	endtask

	// stimulus and verdict
	initial begin : stimulus
		int first;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= REQ_ALLOC;
		cfg_valid     <= 1'b0;
		cfg_index     <= REG_POOL_SIZE;
		cfg_data      <= '0;
		arst_n        <= 1'b0;
		idle_on = 1'b1;
		cur_pool = int'(POOL_RESET);
		guess_used = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: first fit, double free, free at the top entry
		send_request(REQ_ALLOC, 12'hfff);
		send_request(REQ_ALLOC, 12'h000);
		send_request(REQ_RELEASE, 12'd0);
		send_request(REQ_RELEASE, 12'd0);
		send_request(REQ_RELEASE, 12'd4095);
		send_request(REQ_ALLOC, 12'h5a5);

		// pool size above the entry count is clamped
		configure(13'd8191, 1'b0);
		send_request(REQ_RELEASE, 12'd4095);
		send_request(REQ_ALLOC, 12'ha5a);

		// entry zero reserved, tiny pool
		configure(13'd2, 1'b1);
		send_request(REQ_ALLOC, 12'd0);
		send_request(REQ_RELEASE, 12'd1);
		send_request(REQ_ALLOC, 12'd0);
		send_request(REQ_RELEASE, 12'd2);

		// empty pool: nothing to allocate, every index out of range
		configure(13'd0, 1'b1);
		send_request(REQ_ALLOC, 12'd0);
		send_request(REQ_RELEASE, 12'd0);

		// size not above first index, free below first index still allowed
		configure(13'd1, 1'b1);
		send_request(REQ_ALLOC, 12'd0);
		send_request(REQ_RELEASE, 12'd0);
		send_request(REQ_RELEASE, 12'd0);

		configure(13'd1, 1'b0);
		send_request(REQ_ALLOC, 12'd0);
		send_request(REQ_ALLOC, 12'd0);

		// random phases, each filling then draining under one setting
		for (int phase = 0; phase < PHASES; phase++) begin
			first = (phase % 3 == 1) ? 1 : (phase < 3 ? 0 : $urandom_range(1, 0));
			if (phase == PHASES - 1)
				configure(POOL_W'($urandom_range(8191, 1)), first[0]);
			else
				configure(POOL_W'(phase_pool[phase]), first[0]);
			idle_on = (phase % 3 != 2);
			guess_used = 0;
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_random((n < PHASE_ITEMS * 11 / 20) ? phase_fill[phase]
					: 100 - phase_fill[phase]);
		end

		// back to reset settings at the end
		configure(POOL_RESET, 1'b0);
		idle_on = 1'b1;
		send_request(REQ_ALLOC, 12'd0);
		send_request(REQ_RELEASE, 12'd4095);

		wait_drained();
		if (mismatches == 0 && outstanding == 0)
			$display("bitmap_first_fit_allocator test passed");
		else
			$display("bitmap_first_fit_allocator test failed");
		$finish;
	end

	// result side: random stalls plus two long hold-offs that back up the requests
	initial begin : result_sink
		int stall;
		int results_seen;
		m_axis_tready <= 1'b0;
		results_seen = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = idle_on ? $urandom_range(11, 0) : 0;
			if (results_seen == 150 || results_seen == 900)
				stall = HOLD_CYCLES;
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			results_seen++;
		end
	end

endmodule
